FILE: src/rau_pkg.sv
// Package: widths, operation and status codes, controller/datapath link types.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
	localparam int NUM_WIDTH = 32;
	localparam int DEN_WIDTH = 31;
	localparam int OP_W = 3;
	localparam int NUM_W = 32;
	localparam int DEN_W = 31;
	localparam int RES_W = 63;
	localparam int ST_W = 2;
	localparam int WW = 64;
	localparam int MW = 33;
	localparam int KW = 7;
	localparam int CW = 6;

	typedef enum logic [OP_W-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_CMP = 3'd4,
		OP_NEG = 3'd5
	} rau_op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_DIV_ZERO = 2'd2
	} rau_status_t;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic mul3;
		logic sum;
		logic gcd_step;
		logic div_init;
		logic div_step;
		logic out_load;
	} rau_cmd_t;

	typedef struct packed {
		logic early;
		logic is_cmp;
		logic gcd_done;
	} rau_sts_t;
endpackage
`default_nettype wire

FILE: src/rau_if.sv
// Handshake channel interfaces for operand and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface rau_req_if;
	import rau_pkg::*;
	logic valid;
	logic ready;
	logic [OP_W-1:0] operation;
	logic signed [NUM_W-1:0] a_numerator;
	logic [DEN_W-1:0] a_denominator;
	logic signed [NUM_W-1:0] b_numerator;
	logic [DEN_W-1:0] b_denominator;
	modport source (output valid, operation, a_numerator, a_denominator, b_numerator,
		b_denominator, input ready);
	modport sink (input valid, operation, a_numerator, a_denominator, b_numerator,
		b_denominator, output ready);
endinterface

interface rau_rsp_if;
	import rau_pkg::*;
	logic valid;
	logic ready;
	logic signed [RES_W-1:0] result_numerator;
	logic [RES_W-1:0] result_denominator;
	logic is_equal;
	logic is_greater;
	logic is_less;
	logic [ST_W-1:0] status;
	modport source (output valid, result_numerator, result_denominator, is_equal,
		is_greater, is_less, status, input ready);
	modport sink (input valid, result_numerator, result_denominator, is_equal,
		is_greater, is_less, status, output ready);
endinterface
`default_nettype wire

FILE: src/rational_arithmetic_unit_top.sv
// Top level: rational arithmetic unit with gcd reduction.
// One item at a time. Errors and unused codes go from the accept state through the
// first multiply state to the result load; compare also runs the other multiplies
// and the sum. Arithmetic takes the accept state, the multiply and sum states, a
// binary gcd of one shift or subtract per cycle, a step that forms the gcd, then the
// two bit-serial dividers and a load of the result. A finished result waits in the
// output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none
module rational_arithmetic_unit_top (
	input wire logic clk,
	input wire logic arst_n,
	rau_req_if.sink   req,
	rau_rsp_if.source rsp
);
	import rau_pkg::*;

	rau_cmd_t cmd;
	rau_sts_t sts;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rau_datapath u_dp (
		.clk                (clk),
		.cmd                (cmd),
		.sts                (sts),
		.operation          (req.operation),
		.a_numerator        (req.a_numerator),
		.a_denominator      (req.a_denominator),
		.b_numerator        (req.b_numerator),
		.b_denominator      (req.b_denominator),
		.result_numerator   (rsp.result_numerator),
		.result_denominator (rsp.result_denominator),
		.is_equal           (rsp.is_equal),
		.is_greater         (rsp.is_greater),
		.is_less            (rsp.is_less),
		.status             (rsp.status)
	);

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("operand beat taken while busy");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> $onehot0({rsp.is_equal, rsp.is_greater, rsp.is_less}))
		else $error("compare flags not exclusive");
	a_err_den: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.result_denominator == '0)
		else $error("error beat with nonzero denominator");
endmodule
`default_nettype wire

FILE: src/rau_datapath.sv
// Datapath: shared multiplier, binary gcd, twin restoring dividers, result register.
`timescale 1ns / 1ps
`default_nettype none
module rau_datapath (
	input  wire logic                         clk,
	input  wire rau_pkg::rau_cmd_t            cmd,
	output rau_pkg::rau_sts_t                 sts,
	input  wire logic [rau_pkg::OP_W-1:0]     operation,
	input  wire logic [rau_pkg::NUM_W-1:0]    a_numerator,
	input  wire logic [rau_pkg::DEN_W-1:0]    a_denominator,
	input  wire logic [rau_pkg::NUM_W-1:0]    b_numerator,
	input  wire logic [rau_pkg::DEN_W-1:0]    b_denominator,
	output logic signed [rau_pkg::RES_W-1:0]  result_numerator,
	output logic [rau_pkg::RES_W-1:0]         result_denominator,
	output logic                              is_equal,
	output logic                              is_greater,
	output logic                              is_less,
	output logic [rau_pkg::ST_W-1:0]          status
);
	import rau_pkg::*;

	localparam logic [WW-1:0] POS_LIM = {2'b00, {(WW-2){1'b1}}};
	localparam logic [WW-1:0] NEG_LIM = {2'b01, {(WW-2){1'b0}}};

	logic [OP_W-1:0] op_q;
	logic [NUM_WIDTH-1:0] an_q, bn_q;
	logic [DEN_WIDTH-1:0] ad_q, bd_q;
	logic early_q;
	logic [ST_W-1:0] st_q;

	logic signed [MW-1:0] an_x, bn_x, ad_x, bd_x, bn_abs, ma, mb;
	logic signed [2*MW-1:0] prod;
	logic signed [WW-1:0] p1_q, p2_q, p3_q, num;
	logic [WW-1:0] den;
	logic eq_q, gt_q, lt_q, neg_q;
	logic [WW-1:0] x_q, y_q, m_q, d_q, g_q;
	logic [KW-1:0] k_q;
	logic [WW:0] rm_q, rd_q, tm, td;
	logic [WW-1:0] qm_q, qd_q, mm;
	logic ge_m, ge_d;

	logic [DEN_WIDTH-1:0] ad_in, bd_in;
	logic bn_zero_in;

	assign an_x = {{(MW-NUM_WIDTH){an_q[NUM_WIDTH-1]}}, an_q};
	assign bn_x = {{(MW-NUM_WIDTH){bn_q[NUM_WIDTH-1]}}, bn_q};
	assign ad_x = {{(MW-DEN_WIDTH){1'b0}}, ad_q};
	assign bd_x = {{(MW-DEN_WIDTH){1'b0}}, bd_q};
	assign bn_abs = bn_x[MW-1] ? -bn_x : bn_x;

	assign ad_in = a_denominator[DEN_WIDTH-1:0];
	assign bd_in = b_denominator[DEN_WIDTH-1:0];
	assign bn_zero_in = (b_numerator[NUM_WIDTH-1:0] == '0);

	always_comb begin
		ma = an_x;
		mb = bd_x;
		if (cmd.mul1) begin
			ma = an_x;
			mb = (op_q == OP_MUL) ? bn_x : bd_x;
		end else if (cmd.mul2) begin
			ma = bn_x;
			mb = ad_x;
		end else begin
			ma = (op_q == OP_DIV) ? bn_abs : ad_x;
			mb = (op_q == OP_DIV) ? ad_x : bd_x;
		end
	end
	assign prod = ma * mb;

	always_comb begin
		case (op_q)
			OP_ADD:  num = p1_q + p2_q;
			OP_SUB:  num = p1_q - p2_q;
			OP_DIV:  num = bn_x[MW-1] ? -p1_q : p1_q;
			OP_NEG:  num = -WW'(an_x);
			default: num = p1_q;
		endcase
		den = (op_q == OP_NEG) ? WW'(ad_x) : p3_q;
	end

	assign tm = {rm_q[WW-1:0], qm_q[WW-1]};
	assign td = {rd_q[WW-1:0], qd_q[WW-1]};
	assign ge_m = tm >= {1'b0, g_q};
	assign ge_d = td >= {1'b0, g_q};

	assign sts.early = early_q;
	assign sts.is_cmp = (op_q == OP_CMP);
	assign sts.gcd_done = (x_q == '0) || (y_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			an_q <= a_numerator[NUM_WIDTH-1:0];
			bn_q <= b_numerator[NUM_WIDTH-1:0];
			ad_q <= ad_in;
			bd_q <= bd_in;
			if (operation > OP_NEG) begin
				early_q <= 1'b1;
				st_q <= ST_OK;
			end else if (ad_in == '0 || (operation != OP_NEG && bd_in == '0)) begin
				early_q <= 1'b1;
				st_q <= ST_ZERO_DEN;
			end else if (operation == OP_DIV && bn_zero_in) begin
				early_q <= 1'b1;
				st_q <= ST_DIV_ZERO;
			end else begin
				early_q <= 1'b0;
				st_q <= ST_OK;
			end
		end
		if (cmd.mul1) p1_q <= prod[WW-1:0];
		if (cmd.mul2) p2_q <= prod[WW-1:0];
		if (cmd.mul3) p3_q <= prod[WW-1:0];
		if (cmd.sum) begin
			eq_q <= (p1_q == p2_q);
			gt_q <= (p1_q > p2_q);
			lt_q <= (p1_q < p2_q);
			neg_q <= num[WW-1];
			m_q <= num[WW-1] ? WW'(-num) : WW'(num);
			x_q <= num[WW-1] ? WW'(-num) : WW'(num);
			d_q <= den;
			y_q <= den;
			k_q <= '0;
		end
		if (cmd.gcd_step) begin
			if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q >= y_q) begin
				x_q <= x_q - y_q;
			end else begin
				y_q <= y_q - x_q;
			end
		end
		if (cmd.div_init) begin
			g_q <= (x_q | y_q) << k_q;
			rm_q <= '0;
			rd_q <= '0;
			qm_q <= m_q;
			qd_q <= d_q;
		end
		if (cmd.div_step) begin
			rm_q <= ge_m ? tm - {1'b0, g_q} : tm;
			rd_q <= ge_d ? td - {1'b0, g_q} : td;
			qm_q <= {qm_q[WW-2:0], ge_m};
			qd_q <= {qd_q[WW-2:0], ge_d};
		end
		if (cmd.out_load) begin
			status <= st_q;
			result_numerator <= '0;
			result_denominator <= '0;
			is_equal <= 1'b0;
			is_greater <= 1'b0;
			is_less <= 1'b0;
			if (!early_q) begin
				if (op_q == OP_CMP) begin
					is_equal <= eq_q;
					is_greater <= gt_q;
					is_less <= lt_q;
				end else begin
					result_numerator <= neg_q ? RES_W'(-mm) : RES_W'(mm);
					result_denominator <= qd_q[RES_W-1:0];
				end
			end
		end
	end

	always_comb begin
		if (neg_q) mm = (qm_q > NEG_LIM) ? NEG_LIM : qm_q;
		else mm = (qm_q > POS_LIM) ? POS_LIM : qm_q;
	end
endmodule
`default_nettype wire

FILE: src/rau_ctrl.sv
// Controller: sequences multiply, reduce and divide steps and owns the result valid.
`timescale 1ns / 1ps
`default_nettype none
module rau_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire rau_pkg::rau_sts_t sts,
	output rau_pkg::rau_cmd_t      cmd
);
	import rau_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_SUM, S_GCD, S_DIV, S_FIN
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic out_valid_q;
	logic can_load;

	assign out_valid = out_valid_q;
	assign in_ready = (state_q == S_IDLE);
	assign can_load = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_MUL1: cmd.mul1 = 1'b1;
			S_MUL2: cmd.mul2 = 1'b1;
			S_MUL3: cmd.mul3 = 1'b1;
			S_SUM:  cmd.sum = 1'b1;
			S_GCD: begin
				cmd.gcd_step = !sts.gcd_done;
				cmd.div_init = sts.gcd_done;
			end
			S_DIV:  cmd.div_step = 1'b1;
			S_FIN:  cmd.out_load = can_load;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && can_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_MUL1;
				S_MUL1: state_q <= sts.early ? S_FIN : S_MUL2;
				S_MUL2: state_q <= S_MUL3;
				S_MUL3: state_q <= S_SUM;
				S_SUM:  state_q <= sts.is_cmp ? S_FIN : S_GCD;
				S_GCD: begin
					if (sts.gcd_done) begin
						cnt_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(WW-1)) state_q <= S_FIN;
				end
				S_FIN: begin
					if (can_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: bench/rational_arithmetic_unit_top_test.sv
// Testbench: rational arithmetic unit driven with directed and random beats, checked per field.
`timescale 1ns / 1ps
module rational_arithmetic_unit_top_test;
	import rau_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
	localparam logic [63:0] POS_SAT = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_SAT = 64'h4000_0000_0000_0000;

	typedef struct {
		logic [OP_W-1:0] op;
		logic signed [NUM_W-1:0] an;
		logic [DEN_W-1:0] ad;
		logic signed [NUM_W-1:0] bn;
		logic [DEN_W-1:0] bd;
	} operands_t;

	typedef struct {
		logic signed [RES_W-1:0] num;
		logic [RES_W-1:0] den;
		logic eq;
		logic gt;
		logic lt;
		logic [ST_W-1:0] st;
	} fraction_t;

	logic clk;
	logic arst_n;
	rau_req_if req();
	rau_rsp_if rsp();

	rational_arithmetic_unit_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	operands_t pending[$];
	fraction_t awaited[$];
	int failures = 0;
	int accepted = 0;
	bit taken = 0;
	int send_gap = 0;
	int hold_cycles = 0;
	bit long_hold_done = 0;
	bit steady = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic void reduce_into(input longint n, input logic [63:0] d,
			inout fraction_t f);
		logic [63:0] m, x, y, r;
		m = (n < 0) ? 64'(-n) : 64'(n);
		x = m;
		y = d;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		if (x == 0)
			x = 1;
		m = m / x;
		d = d / x;
		if (n < 0) begin
			if (m > NEG_SAT)
				m = NEG_SAT;
			f.num = 63'(-m);
		end else begin
			if (m > POS_SAT)
				m = POS_SAT;
			f.num = 63'(m);
		end
		f.den = 63'(d);
	endfunction

	function automatic fraction_t rational_result(operands_t o);
		fraction_t f;
		longint an, bn, ad, bd, lhs, rhs;
		f = '{default: '0};
		an = o.an;
		bn = o.bn;
		ad = {33'd0, o.ad};
		bd = {33'd0, o.bd};
		if (o.op == OP_SPARE_LO || o.op == OP_SPARE_HI)
			return f;
		if (ad == 0 || (o.op != OP_NEG && bd == 0)) begin
			f.st = ST_ZERO_DEN;
			return f;
		end
		case (o.op)
			OP_ADD: reduce_into(an * bd + bn * ad, ad * bd, f);
			OP_SUB: reduce_into(an * bd - bn * ad, ad * bd, f);
			OP_MUL: reduce_into(an * bn, ad * bd, f);
			OP_DIV: begin
				if (bn == 0)
					f.st = ST_DIV_ZERO;
				else
					reduce_into(bn < 0 ? -(an * bd) : an * bd,
						(bn < 0 ? -bn : bn) * ad, f);
			end
			OP_CMP: begin
				lhs = an * bd;
				rhs = bn * ad;
				f.eq = lhs == rhs;
				f.gt = lhs > rhs;
				f.lt = lhs < rhs;
			end
			default: reduce_into(-an, ad, f);
		endcase
		return f;
	endfunction

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			failures++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
		end
	endtask

	// acceptance of operand beats and checking of result beats
	always @(posedge clk) begin
		fraction_t e;
		operands_t o;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (awaited.size() == 0) begin
					failures++;
					$display("%0t: unexpected result beat, actual num %h den %h st %0d",
						$time, rsp.result_numerator, rsp.result_denominator, rsp.status);
				end else begin
					e = awaited.pop_front();
					check_field("result_numerator", e.num, rsp.result_numerator);
					check_field("result_denominator", e.den, rsp.result_denominator);
					check_field("is_equal", e.eq, rsp.is_equal);
					check_field("is_greater", e.gt, rsp.is_greater);
					check_field("is_less", e.lt, rsp.is_less);
					check_field("status", e.st, rsp.status);
				end
			end
			if (req.valid && req.ready) begin
				o.op = req.operation;
				o.an = req.a_numerator;
				o.ad = req.a_denominator;
				o.bn = req.b_numerator;
				o.bd = req.b_denominator;
				awaited.push_back(rational_result(o));
				accepted++;
				taken = 1;
			end
		end
	end

	function automatic int random_gap();
		int p;
		p = $urandom_range(99);
		if (steady || p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	always @(negedge clk) begin
		operands_t o;
		if (taken) begin
			taken = 0;
			req.valid = 0;
			send_gap = random_gap();
		end
		if (!req.valid && arst_n) begin
			if (send_gap > 0)
				send_gap--;
			else if (pending.size() > 0) begin
				o = pending.pop_front();
				req.operation = o.op;
				req.a_numerator = o.an;
				req.a_denominator = o.ad;
				req.b_numerator = o.bn;
				req.b_denominator = o.bd;
				req.valid = 1;
			end
		end
		// receiver: random stalls and holds, steady phases, plus one long hold-off
		if (!long_hold_done && accepted >= 400) begin
			long_hold_done = 1;
			hold_cycles = 600;
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			rsp.ready = 0;
		end else if (steady)
			rsp.ready = 1;
		else begin
			rsp.ready = random_gap() == 0;
			if ($urandom_range(99) < 4)
				hold_cycles = $urandom_range(60, 10);
		end
		steady = (accepted / 100) % 4 == 2;
	end

	function automatic logic signed [NUM_W-1:0] random_numerator();
		case ($urandom_range(5))
			0: return $signed($urandom_range(40)) - 20;
			1: return 32'sh8000_0000;
			2: return 32'sh7FFF_FFFF;
			3: return $signed($urandom_range(2000)) - 1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DEN_W-1:0] random_denominator();
		case ($urandom_range(9))
			0: return '0;
			1: return 31'h7FFF_FFFF;
			2, 3: return 31'($urandom_range(30, 1));
			4: return 31'($urandom_range(1000, 1));
			default: return 31'($urandom);
		endcase
	endfunction

	task automatic queue_item(logic [OP_W-1:0] op, logic signed [NUM_W-1:0] an,
			logic [DEN_W-1:0] ad, logic signed [NUM_W-1:0] bn, logic [DEN_W-1:0] bd);
		operands_t o;
		o.op = op;
		o.an = an;
		o.ad = ad;
		o.bn = bn;
		o.bd = bd;
		pending.push_back(o);
	endtask

	initial begin
		operands_t o;
		logic [OP_W-1:0] op;
		arst_n = 0;
		req.valid = 0;
		req.operation = OP_ADD;
		req.a_numerator = '0;
		req.a_denominator = '0;
		req.b_numerator = '0;
		req.b_denominator = '0;
		rsp.ready = 0;

		queue_item(OP_ADD, 1, 2, 1, 3);
		queue_item(OP_SUB, 1, 2, 1, 2);
		queue_item(OP_MUL, -3, 4, 2, 9);
		queue_item(OP_DIV, 1, 2, -3, 4);
		queue_item(OP_DIV, -5, 7, 5, 7);
		queue_item(OP_DIV, 1, 2, 0, 5);
		queue_item(OP_CMP, 1, 2, 2, 4);
		queue_item(OP_CMP, 2, 3, 1, 2);
		queue_item(OP_CMP, -1, 3, 1, 3);
		queue_item(OP_NEG, 6, 4, 0, 0);
		queue_item(OP_NEG, 32'sh8000_0000, 1, 7, 3);
		queue_item(OP_ADD, 0, 5, 0, 9);
		queue_item(OP_ADD, 1, 0, 1, 1);
		queue_item(OP_MUL, 1, 1, 1, 0);
		queue_item(OP_NEG, 1, 0, 1, 1);
		queue_item(OP_SPARE_LO, 1, 1, 1, 1);
		queue_item(OP_SPARE_HI, -1, 0, 1, 0);
		queue_item(OP_ADD, 32'sh8000_0000, 31'h7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF);
		queue_item(OP_SUB, 32'sh8000_0000, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
		queue_item(OP_MUL, 32'sh8000_0000, 1, 32'sh8000_0000, 1);
		queue_item(OP_DIV, 32'sh8000_0000, 31'h7FFF_FFFF, 32'sh8000_0000, 1);
		queue_item(OP_DIV, 32'sh7FFF_FFFF, 1, -1, 31'h7FFF_FFFF);
		queue_item(OP_CMP, 32'sh8000_0000, 1, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);

		repeat (850) begin
			op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
				: 3'($urandom_range(5));
			o.an = random_numerator();
			o.bn = random_numerator();
			o.ad = random_denominator();
			o.bd = random_denominator();
			queue_item(op, o.an, o.ad, o.bn, o.bd);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		wait (pending.size() == 0 && !req.valid);
		wait (awaited.size() == 0);
		repeat (300) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#4ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule
